// ===== src/lsow_pkg.sv =====
// ----------------------------------------------------------------------------
// lsow_pkg
// Shared types, constants and helper functions of the lidar sector obstacle
// warning block: field widths, register map, level codes, half-span arithmetic.
// ----------------------------------------------------------------------------
package lsow_pkg;

  // field widths
  localparam int unsigned ANG_W     = 12;
  localparam int unsigned DIST_W    = 12;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned NUM_ZONES = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned REG_IDX_W = 3;

  // default geometry
  localparam int unsigned ZONE_WIDTH_CM_DEF = 45;
  localparam int unsigned MIN_HALF_SPAN_DEF = 100;
  localparam int unsigned ANGLE_STEPS_DEF   = 3600;

  // warning levels
  localparam logic [LVL_W-1:0] LVL_FREE   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MILD   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_SEVERE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register map (word index)
  localparam logic [REG_IDX_W-1:0] REG_SEVERE_MIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SEVERE_MAX    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MILD_MAX      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_BEYOND = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RISE_HITS     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FALL_SCANS    = 3'd5;

  // register reset values
  localparam logic [DIST_W-1:0] SEVERE_MIN_RST    = 12'd50;
  localparam logic [DIST_W-1:0] SEVERE_MAX_RST    = 12'd450;
  localparam logic [DIST_W-1:0] MILD_MAX_RST      = 12'd700;
  localparam logic [DIST_W-1:0] IGNORE_BEYOND_RST = 12'd700;
  localparam logic [CNT_W-1:0]  RISE_HITS_RST     = 4'd2;
  localparam logic [CNT_W-1:0]  FALL_SCANS_RST    = 4'd3;

  // zone centres in quarter turns: front, back, left, right
  localparam int unsigned ZONE_QUARTER [NUM_ZONES] = '{0, 2, 3, 1};

  // atan(2^-i) in millidegrees
  localparam longint CORDIC_MDEG [16] = '{
    45000, 26565, 14036, 7125, 3576, 1790, 895, 448,
    224, 112, 56, 28, 14, 7, 3, 2
  };

  typedef struct packed {
    logic [DIST_W-1:0] severe_min;
    logic [DIST_W-1:0] severe_max;
    logic [DIST_W-1:0] mild_max;
    logic [DIST_W-1:0] ignore_beyond;
    logic [CNT_W-1:0]  rise_hits;
    logic [CNT_W-1:0]  fall_scans;
  } cfg_t;

  // one prepared segment beat
  typedef struct packed {
    logic [ANG_W-1:0] start_ang;
    logic [ANG_W-1:0] stop_ang;
    logic [LVL_W-1:0] lvl;
    logic [ANG_W-1:0] span;
    logic             scan_end;
  } seg_t;

  // per-zone status towards the top level
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             changed;
  } zone_stat_t;

  // shift toward zero
  function automatic longint shr_trunc(longint v, int s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  // half-span in tenths of a degree for distance d (elaboration only)
  function automatic longint hs_tenths(longint d, longint zw, longint minhs);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint t;
    x = d * 2 * (longint'(1) << 20);
    y = zw * (longint'(1) << 20);
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = shr_trunc(y, i);
      dy = shr_trunc(x, i);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + CORDIC_MDEG[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - CORDIC_MDEG[i];
      end
    end
    if (z < 0) z = 0;
    t = z / 100;
    if (t < minhs) t = minhs;
    return t;
  endfunction

  // half-span in angle steps
  function automatic longint hs_steps(longint d, longint zw, longint minhs, longint steps);
    return hs_tenths(d, zw, minhs) * steps / 3600;
  endfunction

  // table depth: one past the farthest distance whose span exceeds the floor
  function automatic int hs_depth(longint zw, longint minhs);
    int last;
    last = 0;
    for (int d = 1; d < (1 << DIST_W); d++) begin
      if (hs_tenths(longint'(d), zw, minhs) > minhs) last = d;
    end
    return last + 1;
  endfunction

  // reduce a raw angle into 0 .. steps-1 by conditional subtraction
  function automatic logic [ANG_W-1:0] mod_steps(logic [ANG_W-1:0] a, int unsigned steps);
    logic [ANG_W:0] r;
    r = {1'b0, a};
    for (int k = 3; k >= 0; k--) begin
      if (32'(r) >= (steps << k)) r = r - (ANG_W+1)'(steps << k);
    end
    return r[ANG_W-1:0];
  endfunction

  // inclusive membership with wrap-around
  function automatic logic in_iv(logic [ANG_W-1:0] a, logic [ANG_W-1:0] s,
                                 logic [ANG_W-1:0] e);
    return (s <= e) ? (a >= s && a <= e) : (a >= s || a <= e);
  endfunction

  function automatic logic overlap(logic [ANG_W-1:0] s1, logic [ANG_W-1:0] e1,
                                   logic [ANG_W-1:0] s2, logic [ANG_W-1:0] e2);
    if (s1 == e1 || s2 == e2) return 1'b0;
    return in_iv(s1, s2, e2) || in_iv(e1, s2, e2) ||
           in_iv(s2, s1, e1) || in_iv(e2, s1, e1);
  endfunction

endpackage

// ===== src/lsow_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsow_cfg_regs
// APB-style register file holding distance bands and stability thresholds.
// ----------------------------------------------------------------------------
module lsow_cfg_regs
  import lsow_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.severe_min    <= SEVERE_MIN_RST;
      cfg_q.severe_max    <= SEVERE_MAX_RST;
      cfg_q.mild_max      <= MILD_MAX_RST;
      cfg_q.ignore_beyond <= IGNORE_BEYOND_RST;
      cfg_q.rise_hits     <= RISE_HITS_RST;
      cfg_q.fall_scans    <= FALL_SCANS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEVERE_MIN:    cfg_q.severe_min    <= pwdata[DIST_W-1:0];
        REG_SEVERE_MAX:    cfg_q.severe_max    <= pwdata[DIST_W-1:0];
        REG_MILD_MAX:      cfg_q.mild_max      <= pwdata[DIST_W-1:0];
        REG_IGNORE_BEYOND: cfg_q.ignore_beyond <= pwdata[DIST_W-1:0];
        REG_RISE_HITS:     cfg_q.rise_hits     <= pwdata[CNT_W-1:0];
        REG_FALL_SCANS:    cfg_q.fall_scans    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (reg_idx)
      REG_SEVERE_MIN:    prdata = DATA_W'(cfg_q.severe_min);
      REG_SEVERE_MAX:    prdata = DATA_W'(cfg_q.severe_max);
      REG_MILD_MAX:      prdata = DATA_W'(cfg_q.mild_max);
      REG_IGNORE_BEYOND: prdata = DATA_W'(cfg_q.ignore_beyond);
      REG_RISE_HITS:     prdata = DATA_W'(cfg_q.rise_hits);
      REG_FALL_SCANS:    prdata = DATA_W'(cfg_q.fall_scans);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/lsow_seg_prep.sv =====
// ----------------------------------------------------------------------------
// lsow_seg_prep
// Front half of the single pass: angle reduction, distance band level and
// half-span lookup for an incoming segment beat.
// ----------------------------------------------------------------------------
module lsow_seg_prep
  import lsow_pkg::*;
#(
  parameter int unsigned ZONE_WIDTH_CM = ZONE_WIDTH_CM_DEF,
  parameter int unsigned MIN_HALF_SPAN = MIN_HALF_SPAN_DEF,
  parameter int unsigned ANGLE_STEPS   = ANGLE_STEPS_DEF
) (
  input  logic [ANG_W-1:0]  start_ang_i,
  input  logic [ANG_W-1:0]  stop_ang_i,
  input  logic [DIST_W-1:0] dist_i,
  input  logic              scan_end_i,
  input  cfg_t              cfg_i,
  output seg_t              seg_o
);

  localparam int unsigned HS_DEPTH = hs_depth(longint'(ZONE_WIDTH_CM),
                                              longint'(MIN_HALF_SPAN));
  localparam int unsigned HS_IDX_W = (HS_DEPTH > 1) ? $clog2(HS_DEPTH) : 1;
  localparam logic [ANG_W-1:0] SPAN_FLOOR = ANG_W'(MIN_HALF_SPAN * ANGLE_STEPS / 3600);

  logic [ANG_W-1:0] span_rom [HS_DEPTH];
  logic [ANG_W-1:0] span;
  logic [LVL_W-1:0] lvl;
  logic             in_range;

  // near-distance half-span table, built at elaboration
  for (genvar g = 0; g < HS_DEPTH; g++) begin : g_rom
    assign span_rom[g] = ANG_W'(hs_steps(longint'(g), longint'(ZONE_WIDTH_CM),
                                         longint'(MIN_HALF_SPAN),
                                         longint'(ANGLE_STEPS)));
  end

  // farther segments use the floor span
  always_comb begin
    if (32'(dist_i) < HS_DEPTH) span = span_rom[dist_i[HS_IDX_W-1:0]];
    else                        span = SPAN_FLOOR;
  end

  // distance band
  assign in_range = (dist_i != '0) && (dist_i <= cfg_i.ignore_beyond);

  always_comb begin
    lvl = LVL_FREE;
    if (in_range) begin
      if (dist_i >= cfg_i.severe_min && dist_i <= cfg_i.severe_max) lvl = LVL_SEVERE;
      else if (dist_i > cfg_i.severe_max && dist_i <= cfg_i.mild_max) lvl = LVL_MILD;
    end
  end

  assign seg_o.start_ang = mod_steps(start_ang_i, ANGLE_STEPS);
  assign seg_o.stop_ang  = mod_steps(stop_ang_i, ANGLE_STEPS);
  assign seg_o.lvl       = lvl;
  assign seg_o.span      = span;
  assign seg_o.scan_end  = scan_end_i;

endmodule

// ===== src/lsow_zone.sv =====
// ----------------------------------------------------------------------------
// lsow_zone
// One direction zone: overlap test, per-scan candidate and rise/fall
// stability filter with the last reported level.
// ----------------------------------------------------------------------------
module lsow_zone
  import lsow_pkg::*;
#(
  parameter int unsigned ANGLE_STEPS = ANGLE_STEPS_DEF,
  parameter int unsigned QUARTER     = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       emit_i,
  input  seg_t       seg_i,
  input  cfg_t       cfg_i,
  output zone_stat_t stat_o
);

  localparam int unsigned CENTRE = ANGLE_STEPS * QUARTER / 4;
  localparam logic [ANG_W:0] LO_BASE = (ANG_W+1)'(CENTRE + ANGLE_STEPS);
  localparam logic [ANG_W:0] HI_BASE = (ANG_W+1)'(CENTRE);
  localparam logic [ANG_W:0] STEPS   = (ANG_W+1)'(ANGLE_STEPS);

  logic [LVL_W-1:0] cand_q, cand_d, cand_new;
  logic [CNT_W-1:0] rise_q, rise_d, fall_q, fall_d;
  logic [LVL_W-1:0] level_q, level_d, rep_q;
  logic [ANG_W:0]   lo_sum, hi_sum;
  logic [ANG_W-1:0] zone_lo, zone_hi;
  logic             hit;

  // zone bounds with wrap
  always_comb begin
    lo_sum = LO_BASE - {1'b0, seg_i.span};
    hi_sum = HI_BASE + {1'b0, seg_i.span};
    if (lo_sum >= STEPS) lo_sum = lo_sum - STEPS;
    if (hi_sum >= STEPS) hi_sum = hi_sum - STEPS;
    zone_lo = lo_sum[ANG_W-1:0];
    zone_hi = hi_sum[ANG_W-1:0];
  end

  // candidate keeps the highest level of the scan
  assign hit = (seg_i.lvl != LVL_FREE) &&
               overlap(seg_i.start_ang, seg_i.stop_ang, zone_lo, zone_hi);
  assign cand_new = (hit && seg_i.lvl > cand_q) ? seg_i.lvl : cand_q;

  // scan-end stability update
  always_comb begin
    rise_d  = rise_q;
    fall_d  = fall_q;
    level_d = level_q;
    cand_d  = cand_new;
    if (seg_i.scan_end) begin
      cand_d = LVL_FREE;
      if (cand_new != LVL_FREE) begin
        fall_d = '0;
        rise_d = (rise_q == CNT_MAX) ? CNT_MAX : rise_q + 1'b1;
        if (rise_d >= cfg_i.rise_hits) level_d = cand_new;
      end else begin
        rise_d = '0;
        fall_d = (fall_q == CNT_MAX) ? CNT_MAX : fall_q + 1'b1;
        if (fall_d >= cfg_i.fall_scans) level_d = LVL_FREE;
      end
    end
  end

  assign stat_o.level   = level_d;
  assign stat_o.changed = seg_i.scan_end && (level_d != rep_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q  <= LVL_FREE;
      rise_q  <= '0;
      fall_q  <= '0;
      level_q <= LVL_FREE;
      rep_q   <= LVL_FREE;
    end else if (step_i) begin
      cand_q  <= cand_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      level_q <= level_d;
      if (emit_i) rep_q <= level_d;
    end
  end

endmodule

// ===== src/lidar_sector_obstacle_warning_top.sv =====
// ----------------------------------------------------------------------------
// lidar_sector_obstacle_warning_top
// Tests lidar segments against four direction zones, filters zone levels
// scan by scan and reports all four levels whenever one of them changes.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   segment  | in        | in_valid_i/in_stall_o | start, end angle, distance,
//            |           |                       | scan_end
//   levels   | out       | out_valid_o/out_stall_i| front, back, left, right
//   config   | in        | psel/penable/pready   | six registers, 4-byte stride
//
// One segment beat per cycle while in_stall_o is low. A beat is registered
// in the input register; as it leaves, the zone logic updates its state and
// a result is registered in the output register. While the output register
// holds an untaken result and the next scan end would produce another, the
// input register holds and in_stall_o rises. Reset clears all zone state and
// loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module lidar_sector_obstacle_warning_top
  import lsow_pkg::*;
#(
  parameter int unsigned ZONE_WIDTH_CM = ZONE_WIDTH_CM_DEF,
  parameter int unsigned MIN_HALF_SPAN = MIN_HALF_SPAN_DEF,
  parameter int unsigned ANGLE_STEPS   = ANGLE_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // segment channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ANG_W-1:0]  seg_start_angle_i,
  input  logic [ANG_W-1:0]  seg_end_angle_i,
  input  logic [DIST_W-1:0] seg_distance_i,
  input  logic              scan_end_i,
  // level channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LVL_W-1:0]  front_level_o,
  output logic [LVL_W-1:0]  back_level_o,
  output logic [LVL_W-1:0]  left_level_o,
  output logic [LVL_W-1:0]  right_level_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg;
  seg_t             seg_in;
  seg_t             s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_adv, in_acc, emit;
  zone_stat_t       stat [NUM_ZONES];
  logic [NUM_ZONES-1:0] changed;
  logic             out_valid_q, out_valid_d;
  logic [LVL_W-1:0] out_lvl_q [NUM_ZONES];

  lsow_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsow_seg_prep #(
    .ZONE_WIDTH_CM (ZONE_WIDTH_CM),
    .MIN_HALF_SPAN (MIN_HALF_SPAN),
    .ANGLE_STEPS   (ANGLE_STEPS)
  ) u_prep (
    .start_ang_i (seg_start_angle_i),
    .stop_ang_i  (seg_end_angle_i),
    .dist_i      (seg_distance_i),
    .scan_end_i  (scan_end_i),
    .cfg_i       (cfg),
    .seg_o       (seg_in)
  );

  // zone units
  for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
    lsow_zone #(
      .ANGLE_STEPS (ANGLE_STEPS),
      .QUARTER     (ZONE_QUARTER[z])
    ) u_zone (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (s1_adv),
      .emit_i (s1_adv & emit),
      .seg_i  (s1_q),
      .cfg_i  (cfg),
      .stat_o (stat[z])
    );
    assign changed[z] = stat[z].changed;
  end

  // handshake: the input register moves on unless a result cannot be placed
  assign emit       = s1_valid_q & (|changed);
  assign s1_adv     = s1_valid_q & (~emit | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_acc | (s1_valid_q & ~s1_adv);

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (s1_adv && emit) out_valid_d = 1'b1;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= seg_in;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      for (int z = 0; z < NUM_ZONES; z++) out_lvl_q[z] <= stat[z].level;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_level_o = out_lvl_q[0];
  assign back_level_o  = out_lvl_q[1];
  assign left_level_o  = out_lvl_q[2];
  assign right_level_o = out_lvl_q[3];

  // stall only while a beat is held
  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // results only come from a scan end
  a_emit_scan_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && emit) |-> s1_q.scan_end)
    else $error("result raised without scan end");

  // a held beat stays in the input register unchanged
  a_hold_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("held segment beat lost or changed");

  // a fresh result never overwrites an untaken one
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(s1_adv && emit))
    else $error("result overwritten while stalled");

endmodule
